[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the scan code matrix checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, masked while reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Expression that must never be true on a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

[design/pcsk_pkg.sv]
// ----------------------------------------------------------------------------
// pcsk_pkg
// Codes, types and E0 remap tables for the scan code to key matrix block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcsk_pkg;

  // Scan code set selection
  localparam logic [1:0] CS_SET1 = 2'd0;
  localparam logic [1:0] CS_SET2 = 2'd1;
  localparam logic [1:0] CS_SET3 = 2'd2;
  localparam logic [1:0] CS_NONE = 2'd3;

  // Prefix state codes
  localparam logic [3:0] P_IDLE         = 4'd0;
  localparam logic [3:0] P1_E0          = 4'd1;
  localparam logic [3:0] P1_E1          = 4'd2;
  localparam logic [3:0] P1_E1_1D       = 4'd3;
  localparam logic [3:0] P1_E1_9D       = 4'd4;
  localparam logic [3:0] P2_E0          = 4'd5;
  localparam logic [3:0] P2_F0          = 4'd6;
  localparam logic [3:0] P2_E0_F0       = 4'd7;
  localparam logic [3:0] P2_E1          = 4'd8;
  localparam logic [3:0] P2_E1_14       = 4'd9;
  localparam logic [3:0] P2_E1_F0       = 4'd10;
  localparam logic [3:0] P2_E1_F0_14    = 4'd11;
  localparam logic [3:0] P2_E1_F0_14_F0 = 4'd12;
  localparam logic [3:0] P3_F0          = 4'd13;

  // Event kinds on the result channel
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_MAKE     = 3'd1;
  localparam logic [2:0] EV_BREAK    = 3'd2;
  localparam logic [2:0] EV_CLEAR    = 3'd3;
  localparam logic [2:0] EV_SELFTEST = 3'd4;
  localparam logic [2:0] EV_BAD      = 3'd5;

  // Fixed cells for special codes
  localparam logic [6:0] CELL_PAUSE1  = 7'h55;
  localparam logic [6:0] CELL_PAUSE2  = 7'h00;
  localparam logic [6:0] CELL_83      = 7'h02;
  localparam logic [6:0] CELL_84_SET2 = 7'h6F;
  localparam logic [6:0] CELL_84_SET3 = 7'h7F;

  // Action chosen by the decoder for one byte
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_KEY,
    ACT_CLEAR,
    ACT_SELFTEST,
    ACT_BAD
  } act_e;

  typedef struct packed {
    logic [3:0] prefix_nx;
    act_e       act;
    logic [6:0] key_idx;
    logic       make;
  } dec_t;

  // Set 1 E0 remap, input already masked to 7 bits
  function automatic logic [6:0] remap_set1(input logic [6:0] c);
    logic [6:0] r;
    case (c)
      7'h37: r = 7'h54;  7'h46: r = 7'h55;  7'h5B: r = 7'h5A;
      7'h5C: r = 7'h5B;  7'h5D: r = 7'h5C;  7'h20: r = 7'h5D;
      7'h2E: r = 7'h5E;  7'h30: r = 7'h5F;  7'h48: r = 7'h60;
      7'h4B: r = 7'h61;  7'h50: r = 7'h62;  7'h4D: r = 7'h63;
      7'h1C: r = 7'h6F;  7'h52: r = 7'h71;  7'h53: r = 7'h72;
      7'h47: r = 7'h74;  7'h4F: r = 7'h75;  7'h49: r = 7'h77;
      7'h51: r = 7'h78;  7'h1D: r = 7'h7A;  7'h38: r = 7'h7C;
      7'h35: r = 7'h7F;  7'h5E: r = 7'h70;  7'h5F: r = 7'h79;
      7'h63: r = 7'h7B;
      default: r = c;
    endcase
    return r;
  endfunction

  // Set 2 E0 remap, only called with codes below 80h
  function automatic logic [6:0] remap_set2(input logic [6:0] c);
    logic [6:0] r;
    case (c)
      7'h11: r = 7'h0F;  7'h14: r = 7'h17;  7'h1F: r = 7'h19;
      7'h27: r = 7'h1F;  7'h2F: r = 7'h5C;  7'h4A: r = 7'h60;
      7'h5A: r = 7'h62;  7'h69: r = 7'h27;  7'h6B: r = 7'h53;
      7'h6C: r = 7'h2F;  7'h70: r = 7'h39;  7'h71: r = 7'h37;
      7'h72: r = 7'h3F;  7'h74: r = 7'h47;  7'h75: r = 7'h4F;
      7'h7A: r = 7'h56;  7'h7D: r = 7'h5E;  7'h7C: r = 7'h6F;
      7'h7E: r = 7'h00;  7'h21: r = 7'h65;  7'h32: r = 7'h6E;
      7'h23: r = 7'h7F;  7'h10: r = 7'h08;  7'h18: r = 7'h10;
      7'h20: r = 7'h18;  7'h28: r = 7'h20;  7'h30: r = 7'h28;
      7'h38: r = 7'h30;  7'h3A: r = 7'h38;  7'h40: r = 7'h40;
      7'h48: r = 7'h48;  7'h2B: r = 7'h50;  7'h34: r = 7'h08;
      7'h3B: r = 7'h10;  7'h15: r = 7'h18;  7'h4D: r = 7'h20;
      7'h50: r = 7'h28;  7'h5E: r = 7'h50;  7'h3F: r = 7'h57;
      7'h37: r = 7'h5F;  7'h03: r = 7'h18;  7'h04: r = 7'h08;
      7'h0B: r = 7'h20;  7'h0C: r = 7'h10;  7'h0D: r = 7'h19;
      7'h79: r = 7'h6D;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[design/pcsk_decode.sv]
// ----------------------------------------------------------------------------
// pcsk_decode
// Combinational byte decoder: prefix tracking and key cell selection for
// code sets 1, 2 and 3.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcsk_decode (
  input  wire logic [1:0]     code_set_i,
  input  wire logic [3:0]     prefix_i,
  input  wire logic [7:0]     byte_i,
  output pcsk_pkg::dec_t      dec_o
);

  logic [3:0] st;
  logic       brk;
  logic       low;   // byte below 80h

  assign low = !byte_i[7];

  always_comb begin
    dec_o.prefix_nx = pcsk_pkg::P_IDLE;
    dec_o.act       = pcsk_pkg::ACT_NONE;
    dec_o.key_idx   = '0;
    dec_o.make      = 1'b0;
    st              = pcsk_pkg::P_IDLE;
    brk             = 1'b0;

    case (code_set_i)
      // ---------------------------------------------------------------- set 1
      pcsk_pkg::CS_SET1: begin
        if (prefix_i inside {[pcsk_pkg::P1_E0:pcsk_pkg::P1_E1_9D]}) begin
          st = prefix_i;
        end
        case (st)
          pcsk_pkg::P1_E0: begin
            // fake shifts are dropped
            if (!(byte_i inside {8'h2A, 8'hAA, 8'h36, 8'hB6})) begin
              dec_o.act     = pcsk_pkg::ACT_KEY;
              dec_o.key_idx = pcsk_pkg::remap_set1(byte_i[6:0]);
              dec_o.make    = low;
            end
          end
          pcsk_pkg::P1_E1: begin
            if (byte_i == 8'h1D) begin
              dec_o.prefix_nx = pcsk_pkg::P1_E1_1D;
            end else if (byte_i == 8'h9D) begin
              dec_o.prefix_nx = pcsk_pkg::P1_E1_9D;
            end else begin
              dec_o.act = pcsk_pkg::ACT_BAD;
            end
          end
          pcsk_pkg::P1_E1_1D: begin
            if (byte_i == 8'h45) begin
              dec_o.act     = pcsk_pkg::ACT_KEY;
              dec_o.key_idx = pcsk_pkg::CELL_PAUSE1;
              dec_o.make    = 1'b1;
            end else begin
              dec_o.act = pcsk_pkg::ACT_BAD;
            end
          end
          pcsk_pkg::P1_E1_9D: begin
            if (byte_i inside {8'hC5, 8'h45}) begin
              dec_o.act     = pcsk_pkg::ACT_KEY;
              dec_o.key_idx = pcsk_pkg::CELL_PAUSE1;
            end else begin
              dec_o.act = pcsk_pkg::ACT_BAD;
            end
          end
          default: begin
            if (byte_i == 8'hE0) begin
              dec_o.prefix_nx = pcsk_pkg::P1_E0;
            end else if (byte_i == 8'hE1) begin
              dec_o.prefix_nx = pcsk_pkg::P1_E1;
            end else begin
              dec_o.act     = pcsk_pkg::ACT_KEY;
              dec_o.key_idx = byte_i[6:0];
              dec_o.make    = low;
            end
          end
        endcase
      end

      // ---------------------------------------------------------------- set 2
      pcsk_pkg::CS_SET2: begin
        if (prefix_i inside {[pcsk_pkg::P2_E0:pcsk_pkg::P2_E1_F0_14_F0]}) begin
          st = prefix_i;
        end
        case (st)
          pcsk_pkg::P2_E0, pcsk_pkg::P2_E0_F0: begin
            if (byte_i inside {8'h12, 8'h59}) begin
              // fake shift, nothing to do
            end else if (st == pcsk_pkg::P2_E0 && byte_i == 8'hF0) begin
              dec_o.prefix_nx = pcsk_pkg::P2_E0_F0;
            end else if (low) begin
              dec_o.act     = pcsk_pkg::ACT_KEY;
              dec_o.key_idx = pcsk_pkg::remap_set2(byte_i[6:0]);
              dec_o.make    = (st == pcsk_pkg::P2_E0);
            end else begin
              dec_o.act = pcsk_pkg::ACT_CLEAR;
            end
          end
          pcsk_pkg::P2_F0: begin
            if (byte_i == 8'h83) begin
              dec_o.act     = pcsk_pkg::ACT_KEY;
              dec_o.key_idx = pcsk_pkg::CELL_83;
            end else if (byte_i == 8'h84) begin
              dec_o.act     = pcsk_pkg::ACT_KEY;
              dec_o.key_idx = pcsk_pkg::CELL_84_SET2;
            end else if (low) begin
              dec_o.act     = pcsk_pkg::ACT_KEY;
              dec_o.key_idx = byte_i[6:0];
            end else begin
              dec_o.act = pcsk_pkg::ACT_CLEAR;
            end
          end
          pcsk_pkg::P2_E1: begin
            if (byte_i == 8'h14) begin
              dec_o.prefix_nx = pcsk_pkg::P2_E1_14;
            end else if (byte_i == 8'hF0) begin
              dec_o.prefix_nx = pcsk_pkg::P2_E1_F0;
            end else begin
              dec_o.act = pcsk_pkg::ACT_BAD;
            end
          end
          pcsk_pkg::P2_E1_14: begin
            if (byte_i == 8'h77) begin
              dec_o.act     = pcsk_pkg::ACT_KEY;
              dec_o.key_idx = pcsk_pkg::CELL_PAUSE2;
              dec_o.make    = 1'b1;
            end else begin
              dec_o.act = pcsk_pkg::ACT_BAD;
            end
          end
          pcsk_pkg::P2_E1_F0: begin
            if (byte_i == 8'h14) begin
              dec_o.prefix_nx = pcsk_pkg::P2_E1_F0_14;
            end else begin
              dec_o.act = pcsk_pkg::ACT_BAD;
            end
          end
          pcsk_pkg::P2_E1_F0_14: begin
            if (byte_i == 8'hF0) begin
              dec_o.prefix_nx = pcsk_pkg::P2_E1_F0_14_F0;
            end else begin
              dec_o.act = pcsk_pkg::ACT_BAD;
            end
          end
          pcsk_pkg::P2_E1_F0_14_F0: begin
            if (byte_i == 8'h77) begin
              dec_o.act     = pcsk_pkg::ACT_KEY;
              dec_o.key_idx = pcsk_pkg::CELL_PAUSE2;
            end else begin
              dec_o.act = pcsk_pkg::ACT_BAD;
            end
          end
          default: begin
            if (byte_i == 8'hE0) begin
              dec_o.prefix_nx = pcsk_pkg::P2_E0;
            end else if (byte_i == 8'hF0) begin
              dec_o.prefix_nx = pcsk_pkg::P2_F0;
            end else if (byte_i == 8'hE1) begin
              dec_o.prefix_nx = pcsk_pkg::P2_E1;
            end else if (byte_i == 8'h83) begin
              dec_o.act     = pcsk_pkg::ACT_KEY;
              dec_o.key_idx = pcsk_pkg::CELL_83;
              dec_o.make    = 1'b1;
            end else if (byte_i == 8'h84) begin
              dec_o.act     = pcsk_pkg::ACT_KEY;
              dec_o.key_idx = pcsk_pkg::CELL_84_SET2;
              dec_o.make    = 1'b1;
            end else if (byte_i == 8'h00) begin
              // keyboard overrun
              dec_o.act = pcsk_pkg::ACT_CLEAR;
            end else if (byte_i inside {8'hAA, 8'hFC}) begin
              dec_o.act = pcsk_pkg::ACT_SELFTEST;
            end else if (low) begin
              dec_o.act     = pcsk_pkg::ACT_KEY;
              dec_o.key_idx = byte_i[6:0];
              dec_o.make    = 1'b1;
            end else begin
              dec_o.act = pcsk_pkg::ACT_CLEAR;
            end
          end
        endcase
      end

      // ---------------------------------------------------------------- set 3
      pcsk_pkg::CS_SET3: begin
        brk = (prefix_i == pcsk_pkg::P3_F0);
        if (byte_i inside {8'h00, 8'hFF}) begin
          dec_o.act = pcsk_pkg::ACT_BAD;
        end else if (!brk && byte_i == 8'hF0) begin
          dec_o.prefix_nx = pcsk_pkg::P3_F0;
        end else if (byte_i == 8'h83) begin
          dec_o.act     = pcsk_pkg::ACT_KEY;
          dec_o.key_idx = pcsk_pkg::CELL_83;
          dec_o.make    = !brk;
        end else if (byte_i == 8'h84) begin
          dec_o.act     = pcsk_pkg::ACT_KEY;
          dec_o.key_idx = pcsk_pkg::CELL_84_SET3;
          dec_o.make    = !brk;
        end else if (low) begin
          dec_o.act     = pcsk_pkg::ACT_KEY;
          dec_o.key_idx = byte_i[6:0];
          dec_o.make    = !brk;
        end else begin
          dec_o.act = pcsk_pkg::ACT_BAD;
        end
      end

      // ------------------------------------------------- no set: bytes ignored
      default: begin
        dec_o.prefix_nx = prefix_i;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/pc_scancode_to_key_matrix.sv]
// ----------------------------------------------------------------------------
// pc_scancode_to_key_matrix
// Keyboard scan byte decoder (code sets 1, 2, 3) that maintains a pressed-key
// matrix and reports one event with the live key count for every byte.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  ---------------------------
//  in        sink       in_valid_i / in_stall_o    scan_byte_i
//  out       source     out_valid_o / out_stall_i  event_kind_o, key_index_o,
//                                                  changed_o, key_count_o
//  cfg       sink       cfg_wr_en_i                cfg_wr_data_i (code set)
//
//  One byte per cycle sustained while the output is not stalled; the event
//  reaches the outputs through the input register, then decode plus matrix
//  update into the result register.
//  The prefix state, key matrix and key count all advance in the same cycle
//  as the result register loads, so each byte sees the previous byte's state.
//  Reset empties the matrix, zeroes the count and selects code set 2.
//  A stalled result holds; the input register then fills and in_stall_o rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pc_scancode_to_key_matrix #(
  parameter int KEY_ROWS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration
  input  wire logic       cfg_wr_en_i,
  input  wire logic [1:0] cfg_wr_data_i,
  // scan byte input
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire logic [7:0] scan_byte_i,
  // event output
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  output      logic [2:0] event_kind_o,
  output      logic [6:0] key_index_o,
  output      logic       changed_o,
  output      logic [7:0] key_count_o
);

  localparam int RowW = $clog2(KEY_ROWS);

  logic                     in_valid_q;
  logic [7:0]               byte_q;
  logic [1:0]               code_set_q;
  logic [3:0]               prefix_q;
  logic [KEY_ROWS-1:0][7:0] key_bits_q;
  logic [KEY_ROWS-1:0][7:0] key_bits_d;
  logic [7:0]               held_count_q;
  logic [7:0]               held_count_d;
  logic                     out_valid_q;
  logic [2:0]               kind_q;
  logic [2:0]               kind_d;
  logic [6:0]               index_q;
  logic [6:0]               index_d;
  logic                     chg_q;
  logic                     chg_d;

  logic                     advance;
  logic                     in_xfer;
  pcsk_pkg::dec_t           dec;
  logic [RowW-1:0]          row;
  logic [2:0]               col;
  logic                     cell_on;

  // Handshake: result register frees the input register
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Byte decode
  pcsk_decode u_decode (
    .code_set_i (code_set_q),
    .prefix_i   (prefix_q),
    .byte_i     (byte_q),
    .dec_o      (dec)
  );

  assign row     = dec.key_idx[3 +: RowW];
  assign col     = dec.key_idx[2:0];
  assign cell_on = key_bits_q[row][col];

  // Matrix update and event build
  always_comb begin
    key_bits_d   = key_bits_q;
    held_count_d = held_count_q;
    kind_d       = pcsk_pkg::EV_NONE;
    index_d      = '0;
    chg_d        = 1'b0;
    case (dec.act)
      pcsk_pkg::ACT_KEY: begin
        kind_d  = dec.make ? pcsk_pkg::EV_MAKE : pcsk_pkg::EV_BREAK;
        index_d = dec.key_idx;
        if (dec.make && !cell_on) begin
          key_bits_d[row][col] = 1'b1;
          held_count_d         = held_count_q + 8'd1;
          chg_d                = 1'b1;
        end else if (!dec.make && cell_on) begin
          key_bits_d[row][col] = 1'b0;
          held_count_d         = held_count_q - 8'd1;
          chg_d                = 1'b1;
        end
      end
      pcsk_pkg::ACT_CLEAR: begin
        kind_d       = pcsk_pkg::EV_CLEAR;
        chg_d        = (held_count_q != 8'd0);
        key_bits_d   = '0;
        held_count_d = '0;
      end
      pcsk_pkg::ACT_SELFTEST: kind_d = pcsk_pkg::EV_SELFTEST;
      pcsk_pkg::ACT_BAD:      kind_d = pcsk_pkg::EV_BAD;
      default:                kind_d = pcsk_pkg::EV_NONE;
    endcase
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      byte_q <= scan_byte_i;
    end
  end

  // Decoder state: code set, prefix, matrix, count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_set_q   <= pcsk_pkg::CS_SET2;
      prefix_q     <= pcsk_pkg::P_IDLE;
      key_bits_q   <= '0;
      held_count_q <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        code_set_q <= cfg_wr_data_i;
        prefix_q   <= pcsk_pkg::P_IDLE;
      end else if (advance) begin
        prefix_q <= dec.prefix_nx;
      end
      if (advance) begin
        key_bits_q   <= key_bits_d;
        held_count_q <= held_count_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q  <= kind_d;
      index_q <= index_d;
      chg_q   <= chg_d;
    end
  end

  // Count register only moves when a new result loads, so it matches the event
  assign out_valid_o  = out_valid_q;
  assign event_kind_o = kind_q;
  assign key_index_o  = index_q;
  assign changed_o    = chg_q;
  assign key_count_o  = held_count_q;

endmodule

`default_nettype wire

[design/pcsk_checker.sv]
// ----------------------------------------------------------------------------
// pcsk_checker
// Port-level checks for the scan code to key matrix block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pcsk_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [2:0] event_kind_o,
  input wire logic [6:0] key_index_o,
  input wire logic       changed_o,
  input wire logic [7:0] key_count_o
);

  // stalled result keeps its transfer content
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(event_kind_o) && $stable(key_index_o) && $stable(key_count_o), "stalled result changed")

  // matrix holds at most 128 keys
  `ASSERT_NEVER(a_count_max, clk_i, rst_ni, out_valid_o && key_count_o > 8'd128, "key count above 128")

  // a clear leaves the matrix empty
  `ASSERT_CLK(a_clear_empty, clk_i, rst_ni, out_valid_o && event_kind_o == pcsk_pkg::EV_CLEAR |-> key_count_o == 8'd0, "count not zero after clear")

  // a make that changed the matrix leaves at least one key held
  `ASSERT_NEVER(a_make_count, clk_i, rst_ni, out_valid_o && event_kind_o == pcsk_pkg::EV_MAKE && changed_o && key_count_o == 8'd0, "make with empty matrix")

  // only make and break events carry a key index
  `ASSERT_NEVER(a_index_zero, clk_i, rst_ni, out_valid_o && event_kind_o != pcsk_pkg::EV_MAKE && event_kind_o != pcsk_pkg::EV_BREAK && key_index_o != 7'd0, "stray key index")

endmodule

bind pc_scancode_to_key_matrix pcsk_checker u_pcsk_checker (.*);

`default_nettype wire
